>>> hw/rtl/inr_pkg.sv
// Package for the integer n-th root core: widths, mode codes, defaults.
// Used by inr_unit and integer_nth_root_core.
`timescale 1ns / 1ps
`default_nettype none
package inr_pkg;
  localparam int VALUE_BITS_DEF = 28;
  localparam int DEG_W = 8;
  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_FLOOR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CEIL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXACT = 2'd2;
endpackage
`default_nettype wire

>>> hw/rtl/inr_unit.sv
// Shared arithmetic unit: saturating multiply step and restoring divide step.
// Depends on inr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module inr_unit import inr_pkg::*; #(
  parameter int VB = VALUE_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          div_mode,
  input  wire logic [VB-1:0] a,
  input  wire logic [VB-1:0] b,
  input  wire logic [VB:0]   rem_in,
  input  wire logic          bit_in,
  output logic [VB-1:0]      prod_sat,
  output logic [VB:0]        rem_out,
  output logic               q_bit
);
  logic [2*VB-1:0] prod;
  logic [VB+1:0]   sh;
  logic [VB+1:0]   diff;
  logic [VB-1:0]   prod_sat_r;
  always_comb begin
    prod = {{VB{1'b0}}, a} * {{VB{1'b0}}, b};
    sh = {rem_in, bit_in};
    diff = sh - {2'b00, b};
    q_bit = !diff[VB+1];
    rem_out = q_bit ? diff[VB:0] : sh[VB:0];
  end
  always_ff @(posedge clk) begin
    if (!div_mode) begin
      prod_sat_r <= (prod[2*VB-1:VB] != '0) ? {VB{1'b1}} : prod[VB-1:0];
    end
  end
  assign prod_sat = prod_sat_r;
endmodule
`default_nettype wire

>>> hw/rtl/integer_nth_root_core.sv
// Integer n-th root core: sequencer around one shared multiply/divide unit.
// Sequence: a zero radicand or a degree-zero ceiling is answered from idle; other degree zero
// and degree 32 and up go straight to the finish state; otherwise a bit scan, then, unless the
// radicand has fewer bits than the degree, the start-guess shift, Newton steps and a final power.
// One transfer at a time; busy is high while working and the next transfer is taken in the
// cycle out_done pulses; the receiver cannot stall. Synchronous active-low reset.
`timescale 1ns / 1ps
`default_nettype none
module integer_nth_root_core import inr_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [KIND_W-1:0]   in_kind,
  input  wire logic [27:0]         in_radicand,
  input  wire logic [DEG_W-1:0]    in_degree,
  output logic                     out_done,
  output logic [27:0]              out_root,
  output logic                     out_no_root
);
  localparam int VB = VALUE_BITS;
  localparam int CW = $clog2(VB + 1);
  localparam logic [VB-1:0] MAXV = {VB{1'b1}};

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_POW   = 4'd1;
  localparam logic [3:0] S_POWW  = 4'd2;
  localparam logic [3:0] S_DIV1  = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_MULW  = 4'd5;
  localparam logic [3:0] S_DIV2  = 4'd6;
  localparam logic [3:0] S_STEP  = 4'd7;
  localparam logic [3:0] S_FPOW  = 4'd8;
  localparam logic [3:0] S_FPOWW = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;
  localparam logic [3:0] S_MSB   = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [VB-1:0] y_r, y_nxt;
  logic [DEG_W-1:0] n_r, n_nxt;
  logic [VB-1:0] cur_r, cur_nxt;
  logic [VB-1:0] acc_r, acc_nxt;
  logic [DEG_W-1:0] cnt_r, cnt_nxt;
  logic [VB-1:0] q_r, q_nxt;
  logic [VB:0] rem_r, rem_nxt;
  logic [CW-1:0] bi_r, bi_nxt;
  logic [VB-1:0] num_r, num_nxt;
  logic [CW-1:0] msb_r, msb_nxt;
  logic [CW-1:0] sh_r, sh_nxt;
  logic first_r, first_nxt;
  logic done_r, done_nxt;
  logic [VB-1:0] res_r, res_nxt;
  logic miss_r, miss_nxt;

  logic div_mode;
  logic [VB-1:0] ua, ub, prod_sat;
  logic [VB:0] rem_out;
  logic q_bit;
  logic [VB-1:0] y_in;

  function automatic logic [VB-1:0] nxt_w_calc(input logic [VB-1:0] p,
                                                input logic [VB-1:0] q);
    logic [VB:0] s;
    s = {1'b0, p} + {1'b0, q};
    return s[VB] ? MAXV : s[VB-1:0];
  endfunction

  inr_unit #(.VB(VB)) u_unit (
    .clk(clk), .div_mode(div_mode), .a(ua), .b(ub),
    .rem_in(rem_r), .bit_in(num_r[bi_r[CW-1:0]]),
    .prod_sat(prod_sat), .rem_out(rem_out), .q_bit(q_bit)
  );

  always_comb begin
    y_in = (in_radicand > 28'(MAXV)) ? MAXV : VB'(in_radicand);
    div_mode = (state_r == S_DIV1) || (state_r == S_DIV2);
    ua = acc_r;
    ub = cur_r;
    if (state_r == S_DIV1) ub = (acc_r == '0) ? VB'(1) : acc_r;
    if (state_r == S_DIV2) ub = VB'(n_r);
    if (state_r == S_MUL) begin
      ua = VB'(n_r - 8'd1);
      ub = cur_r;
    end
  end

  always_comb begin
    state_nxt = state_r; kind_nxt = kind_r; y_nxt = y_r; n_nxt = n_r;
    cur_nxt = cur_r; acc_nxt = acc_r; cnt_nxt = cnt_r; q_nxt = q_r;
    rem_nxt = rem_r; bi_nxt = bi_r; num_nxt = num_r; msb_nxt = msb_r;
    sh_nxt = sh_r; first_nxt = first_r; done_nxt = 1'b0;
    res_nxt = res_r; miss_nxt = miss_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          kind_nxt = in_kind; y_nxt = y_in; n_nxt = in_degree;
          miss_nxt = 1'b0;
          msb_nxt = CW'(VB - 1);
          if (y_in == '0) begin
            res_nxt = '0; done_nxt = 1'b1;
          end else if (in_degree == '0) begin
            if (in_kind == KIND_CEIL) begin
              res_nxt = '0; done_nxt = 1'b1;
            end else begin
              cur_nxt = MAXV; state_nxt = S_FIN;
              acc_nxt = VB'(1);
            end
          end else if (in_degree >= 8'd32) begin
            cur_nxt = VB'(1); acc_nxt = VB'(1); state_nxt = S_FIN;
          end else begin
            state_nxt = S_MSB;
          end
        end
      end
      S_MSB: begin
        if (y_r[msb_r] || msb_r == '0) begin
          if (({1'b0, msb_r} + 1'b1) < (CW + 1)'(n_r)) begin
            cur_nxt = VB'(1); acc_nxt = VB'(1); state_nxt = S_FIN;
            if (n_r == 8'd1) state_nxt = S_FPOW;
          end else begin
            q_nxt = '0; sh_nxt = '0; rem_nxt = {1'b0, VB'(msb_r)};
            state_nxt = S_STEP; first_nxt = 1'b1;
            cnt_nxt = '0;
          end
        end else msb_nxt = msb_r - 1'b1;
      end
      S_STEP: begin
        // start guess: shift = msb / n by repeated subtraction
        if (first_r && (rem_r >= (VB+1)'(n_r))) begin
          rem_nxt = rem_r - (VB+1)'(n_r); sh_nxt = sh_r + 1'b1;
        end else begin
          if (cnt_r == '0) cur_nxt = VB'(1) << sh_r;
          if (cnt_r != '0) first_nxt = 1'b0;
          acc_nxt = VB'(1); cnt_nxt = n_r - 8'd1; state_nxt = S_POW;
          if (cnt_r != '0) begin
            // compare new estimate against current
            if (q_r < cur_r && first_r == 1'b0 && cnt_r == 8'd2) begin
              cur_nxt = q_r;
              if (q_r == '0) begin acc_nxt = '0; state_nxt = S_FIN; end
            end else if (cnt_r == 8'd2) begin
              acc_nxt = VB'(1); cnt_nxt = n_r; state_nxt = S_FPOW;
            end else begin
              cur_nxt = q_r;
              if (q_r == '0) begin acc_nxt = '0; state_nxt = S_FIN; end
            end
          end
        end
      end
      S_POW: begin
        if (cnt_r == '0 || cur_r == VB'(1)) begin
          num_nxt = y_r; rem_nxt = '0; q_nxt = '0; bi_nxt = CW'(VB - 1);
          state_nxt = S_DIV1;
        end else if (acc_r == MAXV) begin
          cnt_nxt = '0;
        end else state_nxt = S_POWW;
      end
      S_POWW: begin
        acc_nxt = prod_sat; cnt_nxt = cnt_r - 1'b1;
        if (cnt_r >= 8'd32) acc_nxt = MAXV;
        state_nxt = S_POW;
      end
      S_DIV1: begin
        rem_nxt = rem_out; q_nxt = {q_r[VB-2:0], q_bit};
        bi_nxt = bi_r - 1'b1;
        if (bi_r == '0) state_nxt = S_MUL;
      end
      S_MUL: state_nxt = S_MULW;
      S_MULW: begin
        acc_nxt = prod_sat;
        state_nxt = S_DIV2;
        rem_nxt = '0; bi_nxt = CW'(VB - 1);
        num_nxt = nxt_w_calc(prod_sat, q_r);
        q_nxt = '0;
      end
      S_DIV2: begin
        rem_nxt = rem_out; q_nxt = {q_r[VB-2:0], q_bit};
        bi_nxt = bi_r - 1'b1;
        if (bi_r == '0) begin
          state_nxt = S_STEP;
          cnt_nxt = first_r ? 8'd1 : 8'd2;
        end
      end
      S_FPOW: begin
        if (cnt_r == '0 || cur_r == VB'(1)) state_nxt = S_FIN;
        else if (acc_r == MAXV) cnt_nxt = '0;
        else state_nxt = S_FPOWW;
      end
      S_FPOWW: begin
        acc_nxt = prod_sat; cnt_nxt = cnt_r - 1'b1;
        state_nxt = S_FPOW;
      end
      S_FIN: begin
        done_nxt = 1'b1; state_nxt = S_IDLE;
        res_nxt = cur_r;
        if (kind_r == KIND_CEIL) begin
          if (acc_r != y_r) res_nxt = cur_r + 1'b1;
        end else if (kind_r == KIND_EXACT) begin
          if (acc_r != y_r) begin res_nxt = '0; miss_nxt = 1'b1; end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; done_r <= 1'b0;
    end else begin
      state_r <= state_nxt; done_r <= done_nxt;
    end
    kind_r <= kind_nxt; y_r <= y_nxt; n_r <= n_nxt; cur_r <= cur_nxt;
    acc_r <= acc_nxt; cnt_r <= cnt_nxt; q_r <= q_nxt; rem_r <= rem_nxt;
    bi_r <= bi_nxt; num_r <= num_nxt; msb_r <= msb_nxt; sh_r <= sh_nxt;
    first_r <= first_nxt; res_r <= res_nxt; miss_r <= miss_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign out_done = done_r;
  assign out_root = 28'(res_r);
  assign out_no_root = miss_r;
endmodule
`default_nettype wire

>>> sim/inr_checker.sv
// Checker for the integer n-th root core: watches accepted requests and done
// strobes, predicts each root and compares field by field. Depends on inr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module inr_checker import inr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              busy,
  input  wire logic [KIND_W-1:0] in_kind,
  input  wire logic [27:0]       in_radicand,
  input  wire logic [DEG_W-1:0]  in_degree,
  input  wire logic              out_done,
  input  wire logic [27:0]       out_root,
  input  wire logic              out_no_root,
  output int                     fail_count,
  output int                     pending
);
  localparam longint unsigned MAXV = (64'd1 << 28) - 1;

  typedef struct packed {
    logic [27:0] root;
    logic        no_root;
  } root_res_t;

  root_res_t roots_due[$];

  function automatic longint unsigned clamp_pow(longint unsigned x, longint unsigned e);
    longint unsigned acc;
    acc = 1;
    if (e == 0 || x == 1) return 1;
    if (x == 0) return 0;
    if (e >= 32) return MAXV;
    for (int i = 0; i < e; i++) begin
      acc = acc * x;
      if (acc > MAXV) return MAXV;
    end
    return acc;
  endfunction

  function automatic longint unsigned newton_step(longint unsigned y, longint unsigned x,
                                                  longint unsigned n);
    longint unsigned p;
    p = clamp_pow(x, n - 1);
    if (p == 0) p = 1;
    return ((n - 1) * x + y / p) / n;
  endfunction

  function automatic longint unsigned floor_nth_root(longint unsigned y, longint unsigned n);
    longint unsigned cur, nxt;
    int msb;
    if (y == 0) return 0;
    if (n == 0) return MAXV;
    if (n >= 32) return 1;
    msb = 0;
    while (msb < 63 && (y >> (msb + 1)) != 0) msb++;
    if (msb + 1 < n) return 1;
    cur = 64'd1 << (msb / n);
    nxt = newton_step(y, cur, n);
    do begin
      cur = nxt;
      if (cur == 0) break;
      nxt = newton_step(y, cur, n);
    end while (nxt < cur);
    return cur;
  endfunction

  function automatic root_res_t predict_root(logic [KIND_W-1:0] kind, logic [27:0] y_in,
                                             logic [DEG_W-1:0] n_in);
    longint unsigned y, n, r;
    root_res_t res;
    y = y_in;
    n = n_in;
    r = 0;
    res.no_root = 1'b0;
    if (y > MAXV) y = MAXV;
    if (kind == KIND_CEIL) begin
      if (y != 0 && n != 0) begin
        r = floor_nth_root(y, n);
        if (clamp_pow(r, n) != y) r++;
      end
    end else if (kind == KIND_EXACT) begin
      if (y != 0) begin
        r = floor_nth_root(y, n);
        if (clamp_pow(r, n) != y) begin
          r = 0;
          res.no_root = 1'b1;
        end
      end
    end else begin
      r = floor_nth_root(y, n);
    end
    res.root = r[27:0];
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("inr_checker: mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    root_res_t want;
    if (rst_n) begin
      if (out_done) begin
        if (roots_due.size() == 0) begin
          report_mismatch($sformatf("unexpected transfer root=%0d no_root=%0b",
                                    out_root, out_no_root));
        end else begin
          want = roots_due.pop_front();
          if (out_root !== want.root)
            report_mismatch($sformatf("root got %0d want %0d", out_root, want.root));
          if (out_no_root !== want.no_root)
            report_mismatch($sformatf("no_root got %0b want %0b", out_no_root, want.no_root));
        end
      end
      if (start && !busy)
        roots_due.push_back(predict_root(in_kind, in_radicand, in_degree));
    end
    pending = roots_due.size();
  end

  final begin
    if (roots_due.size() != 0)
      $display("inr_checker: %0d results never arrived", roots_due.size());
  end
endmodule
`default_nettype wire

>>> sim/tb.sv
// Testbench top for integer_nth_root_core: makes directed and random requests
// with random sender gaps and gives the verdict. Depends on inr_pkg, inr_checker.
`timescale 1ns / 1ps
`default_nettype none
module tb import inr_pkg::*;;
  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [KIND_W-1:0] in_kind;
  logic [27:0]       in_radicand;
  logic [DEG_W-1:0]  in_degree;
  logic              out_done;
  logic [27:0]       out_root;
  logic              out_no_root;
  int                fail_count;
  int                pending;
  int                idle_pct;

  integer_nth_root_core DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_radicand(in_radicand), .in_degree(in_degree),
    .out_done(out_done), .out_root(out_root), .out_no_root(out_no_root)
  );

  inr_checker checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_radicand(in_radicand), .in_degree(in_degree),
    .out_done(out_done), .out_root(out_root), .out_no_root(out_no_root),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hold start until the core takes the transfer.
  task automatic send_root_req(logic [KIND_W-1:0] kind, logic [27:0] y, logic [DEG_W-1:0] n);
    while ($urandom_range(99) < idle_pct) begin
      start       <= 1'b0;
      in_kind     <= logic'($urandom) ? KIND_FLOOR : KIND_EXACT;
      in_radicand <= 28'($urandom);
      in_degree   <= 8'($urandom);
      @(posedge clk);
    end
    start       <= 1'b1;
    in_kind     <= kind;
    in_radicand <= y;
    in_degree   <= n;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [27:0] rand_radicand();
    int w;
    w = $urandom_range(28, 1);
    return 28'(28'($urandom) & ((28'd1 << w) - 1) | (28'd1 << (w - 1)));
  endfunction

  function automatic logic [DEG_W-1:0] rand_degree();
    case ($urandom_range(9))
      0:       return 8'($urandom);
      1:       return 8'($urandom_range(40, 28));
      2:       return 8'($urandom_range(2, 0));
      default: return 8'($urandom_range(12, 1));
    endcase
  endfunction

  // Build a perfect power (clamped to 28'hFFFFFFF when too large) so exact and ceiling modes hit their match path.
  task automatic send_perfect_power(logic [KIND_W-1:0] kind);
    longint unsigned x, p, n;
    n = $urandom_range(8, 1);
    x = $urandom_range(n == 1 ? 1000000 : (n == 2 ? 16383 : 60), 1);
    p = 1;
    for (int i = 0; i < n; i++) p = p * x;
    if (p > 28'hFFFFFFF) p = 28'hFFFFFFF;
    send_root_req(kind, p[27:0], n[7:0]);
  endtask

  initial begin
    logic [KIND_W-1:0] kinds[3];
    kinds = '{KIND_FLOOR, KIND_CEIL, KIND_EXACT};
    rst_n       = 1'b0;
    start       = 1'b0;
    in_kind     = KIND_FLOOR;
    in_radicand = '0;
    in_degree   = '0;
    idle_pct    = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (kinds[k]) begin
      send_root_req(kinds[k], 28'd0, 8'd3);
      send_root_req(kinds[k], 28'hFFFFFFF, 8'd0);
      send_root_req(kinds[k], 28'd1, 8'd0);
      send_root_req(kinds[k], 28'hFFFFFFF, 8'd255);
      send_root_req(kinds[k], 28'd100, 8'd32);
      send_root_req(kinds[k], 28'd8, 8'd5);
      send_root_req(kinds[k], 28'd16384, 8'd2);
      send_root_req(kinds[k], 28'hFFFFFFF, 8'd2);
    end
    send_root_req(2'd3, 28'd1000, 8'd3);

    for (int i = 0; i < 1530; i++) begin
      case (i / 300)
        0:       idle_pct = 0;
        1:       idle_pct = 48;
        2:       idle_pct = 0;
        3:       idle_pct = 9;
        default: idle_pct = 0;
      endcase
      if ($urandom_range(3) == 0)
        send_perfect_power(kinds[$urandom_range(2)]);
      else
        send_root_req(2'($urandom), rand_radicand(), rand_degree());
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2000ms;
    $display("tb: FAIL");
    $finish;
  end
endmodule
`default_nettype wire
